// ----- hdl/glcd_pkg.sv -----
// ----------------------------------------------------------------------------
// glcd_pkg
// Shared types, command codes and the control store of the pixel plot engine.
// ----------------------------------------------------------------------------
package glcd_pkg;

	// default screen geometry
	localparam int COLUMN_WORDS_DEF = 8;
	localparam int PIXEL_ROWS_DEF   = 64;

	// controller command bytes
	localparam logic [7:0] CMD_EXTENDED = 8'h36;
	localparam logic [7:0] CMD_BASIC    = 8'h30;
	localparam logic [7:0] CMD_ADDRESS  = 8'h80;
	localparam logic [7:0] SYNC_BYTE    = 8'hF8;
	localparam logic [7:0] NIBBLE_MASK  = 8'hF0;
	localparam logic [15:0] PIXEL_MSB   = 16'h8000;

	// step addresses of the control program
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_FETCH  = 4'd0;
	localparam step_t ST_READ   = 4'd1;
	localparam step_t ST_MODIFY = 4'd2;
	localparam step_t ST_EXT    = 4'd3;
	localparam step_t ST_ROW    = 4'd4;
	localparam step_t ST_COL    = 4'd5;
	localparam step_t ST_BASIC  = 4'd6;
	localparam step_t ST_DHI    = 4'd7;
	localparam step_t ST_DLO    = 4'd8;

	// condition a step waits on before it advances
	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_PLOT,
		WAIT_FRAME
	} wait_t;

	// byte source for an emitted frame
	typedef enum logic [2:0] {
		SEL_EXT,
		SEL_ROW,
		SEL_COL,
		SEL_BASIC,
		SEL_HI,
		SEL_LO
	} sel_t;

	// one control word
	typedef struct packed {
		logic  accept;
		logic  rd;
		logic  wr;
		logic  emit;
		sel_t  sel;
		logic  rs;
		logic  last;
		wait_t wait_on;
		step_t next;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic take;
		logic in_range;
		logic frame_free;
	} stat_t;

	// control store
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		case (s)
			ST_FETCH:  w = '{1'b1, 1'b0, 1'b0, 1'b0, SEL_EXT,   1'b0, 1'b0, WAIT_PLOT,  ST_READ};
			ST_READ:   w = '{1'b0, 1'b1, 1'b0, 1'b0, SEL_EXT,   1'b0, 1'b0, WAIT_NONE,  ST_MODIFY};
			ST_MODIFY: w = '{1'b0, 1'b0, 1'b1, 1'b0, SEL_EXT,   1'b0, 1'b0, WAIT_NONE,  ST_EXT};
			ST_EXT:    w = '{1'b0, 1'b0, 1'b0, 1'b1, SEL_EXT,   1'b0, 1'b0, WAIT_FRAME, ST_ROW};
			ST_ROW:    w = '{1'b0, 1'b0, 1'b0, 1'b1, SEL_ROW,   1'b0, 1'b0, WAIT_FRAME, ST_COL};
			ST_COL:    w = '{1'b0, 1'b0, 1'b0, 1'b1, SEL_COL,   1'b0, 1'b0, WAIT_FRAME, ST_BASIC};
			ST_BASIC:  w = '{1'b0, 1'b0, 1'b0, 1'b1, SEL_BASIC, 1'b0, 1'b0, WAIT_FRAME, ST_DHI};
			ST_DHI:    w = '{1'b0, 1'b0, 1'b0, 1'b1, SEL_HI,    1'b1, 1'b0, WAIT_FRAME, ST_DLO};
			ST_DLO:    w = '{1'b0, 1'b0, 1'b0, 1'b1, SEL_LO,    1'b1, 1'b1, WAIT_FRAME, ST_FETCH};
			default:   w = '{1'b0, 1'b0, 1'b0, 1'b0, SEL_EXT,   1'b0, 1'b0, WAIT_NONE,  ST_FETCH};
		endcase
		return w;
	endfunction

	// serial frame: sync with rs, high nibble, low nibble
	function automatic logic [23:0] frame_bits(logic rs, logic [7:0] b);
		logic [7:0] sync;
		sync = SYNC_BYTE | {6'b0, rs, 1'b0};
		return {sync, b & NIBBLE_MASK, {b[3:0], 4'h0}};
	endfunction

endpackage

// ----- hdl/glcd_if.sv -----
// ----------------------------------------------------------------------------
// glcd_if
// Request channels of the pixel plot engine: plot requests in, frames out.
// ----------------------------------------------------------------------------
interface glcd_plot_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [6:0] pixel_x;
	logic [5:0] pixel_y;

	modport source (output valid, operation, pixel_x, pixel_y, input ready);
	modport sink   (input valid, operation, pixel_x, pixel_y, output ready);
endinterface

interface glcd_frame_if;
	logic        valid;
	logic        ready;
	logic        register_select;
	logic [7:0]  byte_value;
	logic [23:0] frame_word;
	logic        last_frame;

	modport source (output valid, register_select, byte_value, frame_word, last_frame,
		input ready);
	modport sink   (input valid, register_select, byte_value, frame_word, last_frame,
		output ready);
endinterface

// ----- hdl/glcd_useq.sv -----
// ----------------------------------------------------------------------------
// glcd_useq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module glcd_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  glcd_pkg::stat_t stat,
	output glcd_pkg::ctrl_t ctrl
);

	glcd_pkg::step_t step_q;
	glcd_pkg::step_t step_d;

	// control word for the current step
	always_comb begin
		ctrl = glcd_pkg::ucode(step_q);
	end

	// advance, or hold while the step's condition is not met
	always_comb begin
		case (ctrl.wait_on)
			glcd_pkg::WAIT_NONE:  step_d = ctrl.next;
			glcd_pkg::WAIT_PLOT:  step_d = (stat.take && stat.in_range) ? ctrl.next : step_q;
			glcd_pkg::WAIT_FRAME: step_d = stat.frame_free ? ctrl.next : step_q;
			default:              step_d = glcd_pkg::ST_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= glcd_pkg::ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ----- hdl/glcd_dpath.sv -----
// ----------------------------------------------------------------------------
// glcd_dpath
// Shadow word store, read-modify-write of one word and the frame register.
// ----------------------------------------------------------------------------
module glcd_dpath #(
	parameter int COLUMN_WORDS = glcd_pkg::COLUMN_WORDS_DEF,
	parameter int PIXEL_ROWS   = glcd_pkg::PIXEL_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  glcd_pkg::ctrl_t  ctrl,
	output glcd_pkg::stat_t  stat,
	glcd_plot_if.sink        plot,
	glcd_frame_if.source     frame
);

	localparam int DEPTH = COLUMN_WORDS * PIXEL_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [15:0]   mem [DEPTH];
	logic [CW-1:0] clr_cnt_q;
	logic          init_busy;

	logic          op_q;
	logic [6:0]    x_q;
	logic [5:0]    y_q;
	logic [AW-1:0] addr;
	logic [15:0]   rd_q;
	logic [15:0]   word_new;
	logic [15:0]   word_q;
	logic [7:0]    byte_sel;
	logic          take;

	logic          out_valid_q;
	logic          rs_q;
	logic [7:0]    byte_q;
	logic [23:0]   frame_q;
	logic          last_q;

	// clearing pass over the store after reset
	assign init_busy = (clr_cnt_q != CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (init_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// request side
	assign plot.ready      = ctrl.accept && !init_busy;
	assign take            = plot.valid && plot.ready;
	assign stat.take       = take;
	assign stat.in_range   = ({1'b0, plot.pixel_x[6:4]} < 4'(COLUMN_WORDS)) &&
		({1'b0, plot.pixel_y} < 7'(PIXEL_ROWS));
	assign stat.frame_free = !out_valid_q || frame.ready;

	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= plot.operation;
			x_q  <= plot.pixel_x;
			y_q  <= plot.pixel_y;
		end
	end

	// word index: column * rows + row
	assign addr = AW'(16'(x_q[6:4]) * 16'(PIXEL_ROWS) + 16'(y_q));

	// updated word: set the pixel bit or clear the whole word
	assign word_new = op_q ? 16'h0000 : (rd_q | (glcd_pkg::PIXEL_MSB >> x_q[3:0]));

	// shadow store
	always_ff @(posedge clk) begin
		if (init_busy) begin
			mem[clr_cnt_q[AW-1:0]] <= '0;
		end else if (ctrl.wr) begin
			mem[addr] <= word_new;
		end
		if (ctrl.rd) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			word_q <= word_new;
		end
	end

	// byte carried by the current frame
	always_comb begin
		case (ctrl.sel)
			glcd_pkg::SEL_EXT:   byte_sel = glcd_pkg::CMD_EXTENDED;
			glcd_pkg::SEL_ROW:   byte_sel = glcd_pkg::CMD_ADDRESS | {3'b0, y_q[4:0]};
			glcd_pkg::SEL_COL:   byte_sel = glcd_pkg::CMD_ADDRESS | {4'b0, y_q[5], x_q[6:4]};
			glcd_pkg::SEL_BASIC: byte_sel = glcd_pkg::CMD_BASIC;
			glcd_pkg::SEL_HI:    byte_sel = word_q[15:8];
			glcd_pkg::SEL_LO:    byte_sel = word_q[7:0];
			default:             byte_sel = glcd_pkg::CMD_BASIC;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && stat.frame_free) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && stat.frame_free) begin
			rs_q    <= ctrl.rs;
			byte_q  <= byte_sel;
			frame_q <= glcd_pkg::frame_bits(ctrl.rs, byte_sel);
			last_q  <= ctrl.last;
		end
	end

	assign frame.valid           = out_valid_q;
	assign frame.register_select = rs_q;
	assign frame.byte_value      = byte_q;
	assign frame.frame_word      = frame_q;
	assign frame.last_frame      = last_q;

endmodule

// ----- hdl/glcd_pixel_plot_engine_unit.sv -----
// ----------------------------------------------------------------------------
// glcd_pixel_plot_engine_unit
// Pixel plot engine: updates a shadow word and emits six controller frames per in-range request.
// ----------------------------------------------------------------------------
// Requests are taken in the fetch step, then pass the store read, store write
// and six frame steps (one store port); the first frame is registered in the
// first frame step, and no new request is taken before the last frame step.
// Reset: asynchronous; afterwards a clearing pass zeroes the store, one word a
// cycle, COLUMN_WORDS*PIXEL_ROWS words (512 by default), before requests are taken.
module glcd_pixel_plot_engine_unit #(
	parameter int COLUMN_WORDS = glcd_pkg::COLUMN_WORDS_DEF,
	parameter int PIXEL_ROWS   = glcd_pkg::PIXEL_ROWS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	glcd_plot_if.sink    plot,
	glcd_frame_if.source frame
);

	glcd_pkg::ctrl_t ctrl;
	glcd_pkg::stat_t stat;

	// control program
	glcd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// store and frame datapath
	glcd_dpath #(
		.COLUMN_WORDS (COLUMN_WORDS),
		.PIXEL_ROWS   (PIXEL_ROWS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.plot   (plot),
		.frame  (frame)
	);

endmodule

// ----- hdl/glcd_chk.sv -----
// ----------------------------------------------------------------------------
// glcd_chk
// Port-level checks of the frame channel, bound to the pixel plot engine.
// ----------------------------------------------------------------------------
module glcd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_valid,
	input logic        frame_ready,
	input logic        register_select,
	input logic [7:0]  byte_value,
	input logic [23:0] frame_word,
	input logic        last_frame
);

	// a stalled frame stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid)
		else $error("frame request dropped while stalled");

	// sync byte follows the register select
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame_word[23:16] == (8'hF8 | {6'b0, register_select, 1'b0}))
		else $error("sync byte does not match register select");

	// nibbles follow the byte value
	a_nib: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame_word[15:0] == {byte_value[7:4], 4'h0, byte_value[3:0], 4'h0})
		else $error("frame nibbles do not match byte value");

	// the closing frame of a request carries data
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && last_frame |-> register_select)
		else $error("last frame is not a data frame");

endmodule

bind glcd_pixel_plot_engine_unit glcd_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.frame_valid     (frame.valid),
	.frame_ready     (frame.ready),
	.register_select (frame.register_select),
	.byte_value      (frame.byte_value),
	.frame_word      (frame.frame_word),
	.last_frame      (frame.last_frame)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the pixel plot engine against a shadow-word predictor. Plot and
// clear requests go in with random gaps, the six frames per request come
// back under random stalls, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb;
	import glcd_pkg::*;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;
	localparam int   HALF_ROWS  = 32;
	localparam int   HALF_SHIFT = 8;

	typedef struct packed {
		logic       operation;
		logic [6:0] pixel_x;
		logic [5:0] pixel_y;
	} plot_req_t;

	typedef struct packed {
		logic        register_select;
		logic [7:0]  byte_value;
		logic [23:0] frame_word;
		logic        last_frame;
	} frame_t;

	logic clk;
	logic arst_n;

	glcd_plot_if  plot_ch ();
	glcd_frame_if frame_ch ();

	glcd_pixel_plot_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.plot   (plot_ch),
		.frame  (frame_ch)
	);

	// predictor state and bookkeeping
	logic [15:0] shadow_words [0:COLUMN_WORDS_DEF-1][0:PIXEL_ROWS_DEF-1];
	plot_req_t   plot_requests [$];
	frame_t      expected_frames [$];
	int          requests_total;
	int          requests_taken;
	int          clears_taken;
	int          frames_seen;
	int          mismatches;
	logic        plot_fired;
	logic        frame_fired;
	int          plot_gap;
	int          frame_stall;
	logic        plot_burst;
	logic        frame_burst;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#500000;
		$display("%0t: timeout, %0d frames still expected", $realtime,
			expected_frames.size());
		$display("Mismatches found");
		$finish;
	end

	function automatic frame_t make_frame(logic rs, logic [7:0] b, logic last);
		frame_t f;
		f.register_select = rs;
		f.byte_value      = b;
		f.frame_word      = {SYNC_BYTE | {6'b0, rs, 1'b0}, b[7:4], 4'h0, b[3:0], 4'h0};
		f.last_frame      = last;
		return f;
	endfunction

	// update the shadow word and queue the six frames it causes
	task automatic plot_word_frames(input plot_req_t req);
		int          col;
		int          row;
		logic [15:0] word;
		col = int'(req.pixel_x) / 16;
		row = int'(req.pixel_y);
		// outside the configured screen: ignored
		if (col >= COLUMN_WORDS_DEF || row >= PIXEL_ROWS_DEF)
			return;
		if (req.operation == OP_SET)
			shadow_words[col][row] = shadow_words[col][row] | (PIXEL_MSB >> req.pixel_x[3:0]);
		else
			shadow_words[col][row] = '0;
		word = shadow_words[col][row];
		expected_frames.push_back(make_frame(1'b0, CMD_EXTENDED, 1'b0));
		expected_frames.push_back(make_frame(1'b0, 8'(CMD_ADDRESS + row % HALF_ROWS), 1'b0));
		expected_frames.push_back(make_frame(1'b0,
			8'(CMD_ADDRESS + (row / HALF_ROWS) * HALF_SHIFT + col), 1'b0));
		expected_frames.push_back(make_frame(1'b0, CMD_BASIC, 1'b0));
		expected_frames.push_back(make_frame(1'b1, word[15:8], 1'b0));
		expected_frames.push_back(make_frame(1'b1, word[7:0], 1'b1));
	endtask

	task automatic compare_field(input string name, input logic [23:0] want,
		input logic [23:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $realtime, name, want, got);
		end
	endtask

	task automatic add_request(input logic op, input int x, input int y);
		plot_requests.push_back('{op, 7'(x), 6'(y)});
	endtask

	// request driver
	always @(negedge clk) begin
		plot_req_t nxt;
		if (arst_n) begin
			if (!plot_ch.valid || plot_fired) begin
				if (plot_gap > 0) begin
					plot_gap--;
					plot_ch.valid <= 1'b0;
				end else if (plot_requests.size() > 0) begin
					nxt = plot_requests.pop_front();
					plot_ch.valid     <= 1'b1;
					plot_ch.operation <= nxt.operation;
					plot_ch.pixel_x   <= nxt.pixel_x;
					plot_ch.pixel_y   <= nxt.pixel_y;
					if ($urandom_range(0, 29) == 0)
						plot_burst = !plot_burst;
					plot_gap = plot_burst ? 0 : $urandom_range(0, 17);
				end else begin
					plot_ch.valid <= 1'b0;
				end
			end
		end
	end

	// frame ready with per-frame stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (frame_fired) begin
				if ($urandom_range(0, 39) == 0)
					frame_burst = !frame_burst;
				frame_stall = frame_burst ? 0 : $urandom_range(0, 17);
			end
			if (frame_stall > 0) begin
				frame_stall--;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted requests, check accepted frames
	always @(posedge clk) begin
		plot_req_t req;
		frame_t    got;
		frame_t    want;
		plot_fired  = arst_n && plot_ch.valid && plot_ch.ready;
		frame_fired = arst_n && frame_ch.valid && frame_ch.ready;
		if (plot_fired) begin
			req = '{plot_ch.operation, plot_ch.pixel_x, plot_ch.pixel_y};
			plot_word_frames(req);
			requests_taken++;
			if (req.operation == OP_CLEAR)
				clears_taken++;
		end
		if (frame_fired) begin
			got = '{frame_ch.register_select, frame_ch.byte_value,
				frame_ch.frame_word, frame_ch.last_frame};
			frames_seen++;
			if (expected_frames.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected frame, expected none actual %h", $realtime, got);
			end else begin
				want = expected_frames.pop_front();
				compare_field("register_select", 24'(want.register_select),
					24'(got.register_select));
				compare_field("byte_value", 24'(want.byte_value), 24'(got.byte_value));
				compare_field("frame_word", want.frame_word, got.frame_word);
				compare_field("last_frame", 24'(want.last_frame), 24'(got.last_frame));
			end
		end
	end

	// stimulus and end of run
	initial begin
		int hot_col;
		int hot_row;
		arst_n             = 1'b0;
		plot_ch.valid      = 1'b0;
		plot_ch.operation  = OP_SET;
		plot_ch.pixel_x    = '0;
		plot_ch.pixel_y    = '0;
		frame_ch.ready     = 1'b0;
		plot_fired         = 1'b0;
		frame_fired        = 1'b0;
		plot_gap           = 0;
		frame_stall        = 0;
		plot_burst         = 1'b0;
		frame_burst        = 1'b0;
		requests_taken     = 0;
		clears_taken       = 0;
		frames_seen        = 0;
		mismatches         = 0;
		foreach (shadow_words[c, r])
			shadow_words[c][r] = '0;

		// directed: corners, both halves, both bytes, bits accumulating in one word
		add_request(OP_SET, 0, 0);
		add_request(OP_SET, 15, 0);
		add_request(OP_SET, 7, 0);
		add_request(OP_SET, 8, 0);
		add_request(OP_SET, 127, 63);
		add_request(OP_SET, 112, 32);
		add_request(OP_SET, 16, 31);
		add_request(OP_SET, 0, 63);
		add_request(OP_SET, 127, 0);
		add_request(OP_SET, 85, 42);
		add_request(OP_SET, 42, 21);
		add_request(OP_CLEAR, 5, 0);
		add_request(OP_SET, 3, 0);
		add_request(OP_CLEAR, 127, 63);
		add_request(OP_CLEAR, 64, 40);
		add_request(OP_CLEAR, 0, 0);
		add_request(OP_SET, 127, 63);

		// random: mostly a few hot words that fill up, some scattered, some clears
		hot_col = $urandom_range(0, 7);
		hot_row = $urandom_range(0, 63);
		for (int n = 0; n < 300; n++) begin
			if (n % 40 == 0) begin
				hot_col = $urandom_range(0, 7);
				hot_row = $urandom_range(0, 60);
			end
			if ($urandom_range(0, 9) < 7)
				add_request($urandom_range(0, 7) == 0 ? OP_CLEAR : OP_SET,
					hot_col * 16 + $urandom_range(0, 15), hot_row + $urandom_range(0, 3));
			else
				add_request(1'($urandom_range(0, 1)), $urandom_range(0, 127),
					$urandom_range(0, 63));
		end
		requests_total = plot_requests.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (requests_taken < requests_total)
			@(negedge clk);
		while (expected_frames.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (expected_frames.size() > 0) begin
			mismatches++;
			$display("%0t: %0d frames never arrived", $realtime, expected_frames.size());
		end
		$display("Run covered %0d plot requests (%0d word clears) and %0d frames checked",
			requests_taken, clears_taken, frames_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
